// File: rtl/core/vhb_pkg.sv
// Shared types and constants for the value histogram binner.
`timescale 1ns / 1ps
package vhb_pkg;

    localparam int VALUE_W   = 64;
    localparam int COUNT_W   = 11;
    localparam int BAR_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_VALUES = 1024;
    localparam int DEF_NUM_BINS   = 10;
    localparam int DEF_BAR_MAX    = 50;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_USE_OVERRIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH   = 2'd2;

    localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

    // Bounds of one closed set, handed from the front to the back.
    typedef struct packed {
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
    } job_t;

    // Active range settings.
    typedef struct packed {
        logic               use_override;
        logic [VALUE_W-1:0] range_low;
        logic [VALUE_W-1:0] range_high;
    } cfg_t;

endpackage

// File: rtl/core/vhb_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vhb_div
    import vhb_pkg::*;
#(
    parameter int W = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dv_reg;
    logic [W:0]    trial;
    logic [W-1:0]  rem_next;
    logic          bit_next;

    // One shift and subtract step.
    always_comb
    begin
        trial = {rem_reg, quo_reg[W-1]};
        if (trial >= {1'b0, dv_reg})
        begin
            rem_next = W'(trial - {1'b0, dv_reg});
            bit_next = 1'b1;
        end
        else
        begin
            rem_next = trial[W-1:0];
            bit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CW'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dv_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[W-2:0], bit_next};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/vhb_front.sv
// Front end: takes items, keeps min and max, hands closed sets to the back end.
`timescale 1ns / 1ps
module vhb_front
    import vhb_pkg::*;
#(
    parameter int MAX_VALUES = DEF_MAX_VALUES,
    parameter int CNT_W      = $clog2(MAX_VALUES + 1),
    parameter int AW         = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [VALUE_W-1:0] sample_value,
    input  logic               is_final,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [VALUE_W-1:0] wr_data,
    output logic               job_valid,
    input  logic               job_take,
    output job_t               job,
    output logic [CNT_W-1:0]   job_count
);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [VALUE_W-1:0] min_reg, min_next;
    logic [VALUE_W-1:0] max_reg, max_next;
    logic               job_valid_reg;
    job_t               job_reg;
    logic [CNT_W-1:0]   job_count_reg;
    logic               room;

    // Store the sample and fold it into the running bounds.
    always_comb
    begin
        room       = (count_reg < CNT_W'(MAX_VALUES));
        count_next = count_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        if (accept && room)
        begin
            count_next = count_reg + 1'b1;
            if (sample_value < min_reg)
                min_next = sample_value;
            if (sample_value > max_reg)
                max_next = sample_value;
        end
    end

    assign wr_en   = accept && room;
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = sample_value;

    // The final item closes the set into the single-entry job queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_reg       <= ALL_ONES;
            max_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_take)
                job_valid_reg <= 1'b0;
            if (accept && is_final)
            begin
                job_valid_reg <= 1'b1;
                count_reg     <= '0;
                min_reg       <= ALL_ONES;
                max_reg       <= '0;
            end
            else
            begin
                count_reg <= count_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_final)
        begin
            job_reg.lo    <= min_next;
            job_reg.hi    <= max_next;
            job_count_reg <= count_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;
    assign job_count = job_count_reg;

endmodule

// File: rtl/core/vhb_back.sv
// Back end: value store, bin width, bin counting and result sequencing.
`timescale 1ns / 1ps
module vhb_back
    import vhb_pkg::*;
#(
    parameter int MAX_VALUES = DEF_MAX_VALUES,
    parameter int NUM_BINS   = DEF_NUM_BINS,
    parameter int BAR_MAX    = DEF_BAR_MAX,
    parameter int CNT_W      = $clog2(MAX_VALUES + 1),
    parameter int AW         = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [VALUE_W-1:0] wr_data,
    input  logic               job_valid,
    output logic               job_take,
    input  job_t               job,
    input  logic [CNT_W-1:0]   job_count,
    input  cfg_t               cfg,
    output logic               active,
    output logic               result_strobe,
    output logic [VALUE_W-1:0] bin_low,
    output logic [VALUE_W-1:0] bin_high,
    output logic [COUNT_W-1:0] bin_count,
    output logic [BAR_W-1:0]   bar_length,
    output logic               final_bin
);

    localparam int CI_W = $clog2(NUM_BINS);
    localparam int BM_W = $clog2(BAR_MAX + 1);
    localparam int BN_W = CNT_W + BM_W;
    localparam logic [CI_W-1:0] LAST_BIN = CI_W'(NUM_BINS - 1);

    // Width division by NUM_BINS: eight dividend bits per cycle.
    localparam int DIV_STEP = 8;
    localparam int DIV_CYC  = VALUE_W / DIV_STEP;
    localparam int DS_W     = $clog2(DIV_CYC);
    localparam logic [7:0] NB_DIV = 8'(NUM_BINS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_WAIT = 4'd3;
    localparam logic [3:0] S_BIN  = 4'd4;
    localparam logic [3:0] S_MAX  = 4'd5;
    localparam logic [3:0] S_BAR  = 4'd6;
    localparam logic [3:0] S_BARW = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [VALUE_W-1:0] mem [MAX_VALUES];
    logic [VALUE_W-1:0] rdata_reg;

    logic [3:0]         state_reg;
    logic [VALUE_W-1:0] lo_reg, width_reg, d_reg, bound_reg, lo_acc_reg;
    logic [CNT_W-1:0]   job_cnt_reg, rd_idx_reg, maxc_reg;
    logic [CI_W-1:0]    cidx_reg;
    logic               clr_done_reg, width_ok_reg;
    logic [BM_W-1:0]    bar_reg;
    logic [CNT_W-1:0]   counters_reg [NUM_BINS];
    logic [CNT_W-1:0]   cur_cnt;

    logic [VALUE_W-1:0] wq_reg, wq_next;
    logic [7:0]         wrem_reg, wrem_next;
    logic [DS_W-1:0]    wstep_reg;

    logic [VALUE_W-1:0] sel_lo, sel_hi;
    logic               bdiv_start, bdiv_done;
    logic [BN_W-1:0]    bdiv_q;

    // Value store: one write port from the front, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    // Bounds of the set, with the override applied where it is allowed.
    always_comb
    begin
        sel_lo = job.lo;
        sel_hi = job.hi;
        if (cfg.use_override && (job.lo < job.hi))
        begin
            sel_lo = cfg.range_low;
            sel_hi = cfg.range_high;
        end
    end

    // Long division by the bin count, shift and subtract over one byte.
    always_comb
    begin
        wq_next   = wq_reg;
        wrem_next = wrem_reg;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            wrem_next = {wrem_next[6:0], wq_next[VALUE_W-1]};
            wq_next   = {wq_next[VALUE_W-2:0], 1'b0};
            if (wrem_next >= NB_DIV)
            begin
                wrem_next  = wrem_next - NB_DIV;
                wq_next[0] = 1'b1;
            end
        end
    end

    assign cur_cnt    = counters_reg[cidx_reg];
    assign job_take   = (state_reg == S_IDLE) && job_valid;
    assign bdiv_start = (state_reg == S_BAR) && (maxc_reg >= CNT_W'(BAR_MAX));

    vhb_div #(.W(BN_W)) u_bar_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (bdiv_start),
        .dividend (BN_W'(cur_cnt) * BN_W'(BAR_MAX)),
        .divisor  (BN_W'(maxc_reg)),
        .done     (bdiv_done),
        .quotient (bdiv_q)
    );

    // Sequencer: width, clearing sweep, store walk, max scan, result emission.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cidx_reg     <= '0;
            rd_idx_reg   <= '0;
            clr_done_reg <= 1'b0;
            width_ok_reg <= 1'b0;
            wstep_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        lo_reg       <= sel_lo;
                        job_cnt_reg  <= job_count;
                        wq_reg       <= sel_hi - sel_lo;
                        wrem_reg     <= '0;
                        wstep_reg    <= '0;
                        cidx_reg     <= '0;
                        clr_done_reg <= 1'b0;
                        width_ok_reg <= 1'b0;
                        state_reg    <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!clr_done_reg)
                    begin
                        counters_reg[cidx_reg] <= '0;
                        if (cidx_reg == LAST_BIN)
                            clr_done_reg <= 1'b1;
                        else
                            cidx_reg <= cidx_reg + 1'b1;
                    end
                    if (!width_ok_reg)
                    begin
                        wq_reg   <= wq_next;
                        wrem_reg <= wrem_next;
                        if (wstep_reg == DS_W'(DIV_CYC - 1))
                        begin
                            width_reg    <= wq_next;
                            width_ok_reg <= 1'b1;
                        end
                        else
                        begin
                            wstep_reg <= wstep_reg + 1'b1;
                        end
                    end
                    if (clr_done_reg && width_ok_reg)
                    begin
                        rd_idx_reg <= '0;
                        state_reg  <= S_RD;
                    end
                end
                S_RD:
                begin
                    if (rd_idx_reg == job_cnt_reg)
                    begin
                        cidx_reg  <= '0;
                        maxc_reg  <= '0;
                        state_reg <= S_MAX;
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (rdata_reg < lo_reg)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        state_reg  <= S_RD;
                    end
                    else if (width_reg == '0)
                    begin
                        if (rdata_reg == lo_reg)
                            counters_reg[0] <= counters_reg[0] + 1'b1;
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        state_reg  <= S_RD;
                    end
                    else
                    begin
                        d_reg     <= rdata_reg - lo_reg;
                        bound_reg <= width_reg;
                        cidx_reg  <= '0;
                        state_reg <= S_BIN;
                    end
                end
                S_BIN:
                begin
                    // Step through the bin edges one width at a time.
                    if (d_reg < bound_reg)
                    begin
                        counters_reg[cidx_reg] <= cur_cnt + 1'b1;
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        state_reg  <= S_RD;
                    end
                    else if (cidx_reg == LAST_BIN)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        state_reg  <= S_RD;
                    end
                    else
                    begin
                        cidx_reg  <= cidx_reg + 1'b1;
                        bound_reg <= bound_reg + width_reg;
                    end
                end
                S_MAX:
                begin
                    if (cur_cnt > maxc_reg)
                        maxc_reg <= cur_cnt;
                    if (cidx_reg == LAST_BIN)
                    begin
                        cidx_reg   <= '0;
                        lo_acc_reg <= lo_reg;
                        state_reg  <= S_BAR;
                    end
                    else
                    begin
                        cidx_reg <= cidx_reg + 1'b1;
                    end
                end
                S_BAR:
                begin
                    if (bdiv_start)
                    begin
                        state_reg <= S_BARW;
                    end
                    else
                    begin
                        bar_reg   <= BM_W'(cur_cnt);
                        state_reg <= S_EMIT;
                    end
                end
                S_BARW:
                begin
                    if (bdiv_done)
                    begin
                        bar_reg   <= BM_W'(bdiv_q);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    lo_acc_reg <= lo_acc_reg + width_reg;
                    if (cidx_reg == LAST_BIN)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        cidx_reg  <= cidx_reg + 1'b1;
                        state_reg <= S_BAR;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign active        = (state_reg != S_IDLE);
    assign result_strobe = (state_reg == S_EMIT);
    assign bin_low       = lo_acc_reg;
    assign bin_high      = lo_acc_reg + width_reg;
    assign bin_count     = COUNT_W'(cur_cnt);
    assign bar_length    = BAR_W'(bar_reg);
    assign final_bin     = result_strobe && (cidx_reg == LAST_BIN);

endmodule

// File: rtl/core/value_histogram_binner.sv
// Top level of the value histogram binner.
`timescale 1ns / 1ps
// Loads unsigned 64-bit values, one item per cycle while busy is low, into an
// internal store while tracking their minimum and maximum. The item with
// is_final set closes the set; the block then raises busy and bins the stored
// values into NUM_BINS equal-width bins and presents one result per bin, each
// for a single cycle marked by result_strobe, the last one with final_bin set.
// The receiver cannot stall, so results come out at the block's own pace.
// Binning first clears the bin counters, during which a shift-and-subtract
// division by NUM_BINS gives the bin width, then makes a registered store read
// and a walk over the bin edges for each stored value, scans the bins for the
// largest, and per bin either takes the count as the bar or, when the largest
// bin reaches BAR_MAX, runs the bar scaling division. Items are not taken while
// busy is high.
module value_histogram_binner
    import vhb_pkg::*;
#(
    parameter int MAX_VALUES = DEF_MAX_VALUES,
    parameter int NUM_BINS   = DEF_NUM_BINS,
    parameter int BAR_MAX    = DEF_BAR_MAX
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [VALUE_W-1:0]   sample_value,
    input  logic                 is_final,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]   cfg_data,
    output logic                 result_strobe,
    output logic [VALUE_W-1:0]   bin_low,
    output logic [VALUE_W-1:0]   bin_high,
    output logic [COUNT_W-1:0]   bin_count,
    output logic [BAR_W-1:0]     bar_length,
    output logic                 final_bin
);

    localparam int CNT_W = $clog2(MAX_VALUES + 1);
    localparam int AW    = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

    cfg_t               cfg_reg;
    logic               accept;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               job_valid;
    logic               job_take;
    job_t               job;
    logic [CNT_W-1:0]   job_count;
    logic               back_active;

    assign busy      = job_valid || back_active;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_USE_OVERRIDE: cfg_reg.use_override <= cfg_data[0];
                REG_RANGE_LOW:    cfg_reg.range_low    <= cfg_data;
                REG_RANGE_HIGH:   cfg_reg.range_high   <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    vhb_front #(
        .MAX_VALUES (MAX_VALUES),
        .CNT_W      (CNT_W),
        .AW         (AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .sample_value (sample_value),
        .is_final     (is_final),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .job_valid    (job_valid),
        .job_take     (job_take),
        .job          (job),
        .job_count    (job_count)
    );

    vhb_back #(
        .MAX_VALUES (MAX_VALUES),
        .NUM_BINS   (NUM_BINS),
        .BAR_MAX    (BAR_MAX),
        .CNT_W      (CNT_W),
        .AW         (AW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .job_valid     (job_valid),
        .job_take      (job_take),
        .job           (job),
        .job_count     (job_count),
        .cfg           (cfg_reg),
        .active        (back_active),
        .result_strobe (result_strobe),
        .bin_low       (bin_low),
        .bin_high      (bin_high),
        .bin_count     (bin_count),
        .bar_length    (bar_length),
        .final_bin     (final_bin)
    );

`ifndef SYNTHESIS
    // Results only come out while the block reports busy.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> busy)
        else $error("result strobe while idle");

    // A closing item makes the block busy on the next cycle.
    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && is_final) |=> busy)
        else $error("final item did not start binning");

    // Bars never exceed the scale limit.
    a_bar_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (32'(bar_length) <= 32'(BAR_MAX)))
        else $error("bar length above limit");

    // The last bin flag only travels with a result.
    a_final_bin: assert property (@(posedge clk) disable iff (!rst_n)
        final_bin |-> result_strobe)
        else $error("final bin flag without result");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the value histogram binner.
`timescale 1ns / 1ps
module tb;
    import vhb_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int BINS        = 10;
    localparam int BAR_LIMIT   = 50;
    localparam int SETTLE      = 40;
    localparam int BIG_SET     = 60;

    typedef struct {
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        logic [COUNT_W-1:0] cnt;
        logic [BAR_W-1:0]   bar;
        logic               last;
    } bin_result_t;

    // One row of the directed part; chk marks rows with a typed expectation.
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               fin;
        logic               chk;
        logic [VALUE_W-1:0] exp_lo;
        logic [COUNT_W-1:0] exp_cnt0;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [VALUE_W-1:0]   sample_value;
    logic                 is_final;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VALUE_W-1:0]   cfg_data;
    logic                 result_strobe;
    logic [VALUE_W-1:0]   bin_low;
    logic [VALUE_W-1:0]   bin_high;
    logic [COUNT_W-1:0]   bin_count;
    logic [BAR_W-1:0]     bar_length;
    logic                 final_bin;

    value_histogram_binner DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_value(sample_value), .is_final(is_final),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_strobe(result_strobe), .bin_low(bin_low), .bin_high(bin_high),
        .bin_count(bin_count), .bar_length(bar_length), .final_bin(final_bin)
    );

    // Predictor state: the open set and the active range settings.
    logic [VALUE_W-1:0] set_values [STORE_DEPTH];
    int                 set_size;
    logic [VALUE_W-1:0] set_min;
    logic [VALUE_W-1:0] set_max;
    cfg_t               range_cfg;
    bin_result_t        pending_bins [$];
    int                 errors;
    bit                 quiet;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string msg);
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        end
    endtask

    // Store one accepted item and, on the final one, queue the ten bin results.
    task automatic bin_stored_set(input logic [VALUE_W-1:0] v, input logic fin);
        logic [VALUE_W-1:0] lo_b, hi_b, width, q;
        int counts [BINS];
        int largest;
        bin_result_t r;
        begin
            if (set_size < STORE_DEPTH)
            begin
                set_values[set_size] = v;
                set_size++;
                if (v < set_min) set_min = v;
                if (v > set_max) set_max = v;
            end
            if (fin)
            begin
                lo_b = set_min;
                hi_b = set_max;
                if (range_cfg.use_override && lo_b < hi_b)
                begin
                    lo_b = range_cfg.range_low;
                    hi_b = range_cfg.range_high;
                end
                width = (hi_b - lo_b) / BINS;
                for (int b = 0; b < BINS; b++) counts[b] = 0;
                for (int i = 0; i < set_size; i++)
                begin
                    if (set_values[i] >= lo_b)
                    begin
                        if (width == 0)
                        begin
                            if (set_values[i] == lo_b) counts[0]++;
                        end
                        else
                        begin
                            q = (set_values[i] - lo_b) / width;
                            if (q < BINS) counts[q]++;
                        end
                    end
                end
                largest = 0;
                for (int b = 0; b < BINS; b++)
                    if (counts[b] > largest) largest = counts[b];
                for (int b = 0; b < BINS; b++)
                begin
                    r.lo   = lo_b + VALUE_W'(b) * width;
                    r.hi   = r.lo + width;
                    r.cnt  = COUNT_W'(counts[b]);
                    r.bar  = (largest >= BAR_LIMIT) ? BAR_W'(counts[b] * BAR_LIMIT / largest)
                                                    : BAR_W'(counts[b]);
                    r.last = (b == BINS - 1);
                    pending_bins.push_back(r);
                end
                set_size = 0;
                set_min  = ALL_ONES;
                set_max  = '0;
            end
        end
    endtask

    // Result checker: every strobed item is compared with the oldest expectation.
    always @(posedge clk)
    begin
        bin_result_t e;
        if (rst_n && result_strobe)
        begin
            if (pending_bins.size() == 0)
                report("unexpected bin result");
            else
            begin
                e = pending_bins.pop_front();
                if (bin_low !== e.lo)
                    report($sformatf("bin_low %h, expected %h", bin_low, e.lo));
                if (bin_high !== e.hi)
                    report($sformatf("bin_high %h, expected %h", bin_high, e.hi));
                if (bin_count !== e.cnt)
                    report($sformatf("bin_count %0d, expected %0d", bin_count, e.cnt));
                if (bar_length !== e.bar)
                    report($sformatf("bar_length %0d, expected %0d", bar_length, e.bar));
                if (final_bin !== e.last)
                    report($sformatf("final_bin %b, expected %b", final_bin, e.last));
            end
        end
    end

    // Present one item, with an occasional gap first, and wait until it is taken.
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic fin);
        begin
            if (!quiet && $urandom_range(0, 99) < 15)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            start        <= 1'b1;
            sample_value <= v;
            is_final     <= fin;
            do @(posedge clk); while (busy);
            bin_stored_set(v, fin);
        end
    endtask

    // Hold the sender off until every expected bin has come, then let the block settle.
    task automatic wait_drain();
        begin
            start <= 1'b0;
            while (pending_bins.size() != 0) @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] d);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= d;
            do @(posedge clk); while (!cfg_ready);
            case (idx)
                REG_USE_OVERRIDE: range_cfg.use_override = d[0];
                REG_RANGE_LOW:    range_cfg.range_low    = d;
                REG_RANGE_HIGH:   range_cfg.range_high   = d;
                default: ;
            endcase
        end
    endtask

    task automatic set_range(input logic ov, input logic [VALUE_W-1:0] lo,
                             input logic [VALUE_W-1:0] hi);
        begin
            wait_drain();
            cfg_write(REG_RANGE_LOW, lo);
            cfg_write(REG_RANGE_HIGH, hi);
            cfg_write(REG_USE_OVERRIDE, {63'd0, ov});
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Random sets: mostly clustered values so bins fill, some fully random.
    task automatic random_sets(input int items);
        int sent, n, mode;
        logic [VALUE_W-1:0] base, span, v;
        begin
            sent = 0;
            n = 1;
            while (sent < items)
            begin
                mode = $urandom_range(0, 3);
                base = {$urandom, $urandom};
                span = (mode == 0) ? 64'd1 : (mode == 1) ? 64'd200 : 64'h10_0000;
                for (int i = 0; i < n; i++)
                begin
                    v = (mode == 3) ? {$urandom, $urandom} : base + ({$urandom, $urandom} % span);
                    send_item(v, i == n - 1);
                end
                sent += n;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 10);
            end
        end
    endtask

    stim_row_t directed [] = '{
        '{64'd5,     1'b1, 1'b1, 64'd5,     11'd1},
        '{ALL_ONES,  1'b1, 1'b1, ALL_ONES,  11'd1},
        '{64'd0,     1'b1, 1'b1, 64'd0,     11'd1},
        '{64'd0,     1'b0, 1'b0, 64'd0,     11'd0},
        '{ALL_ONES,  1'b1, 1'b1, 64'd0,     11'd1},
        '{64'd100,   1'b0, 1'b0, 64'd0,     11'd0},
        '{64'd100,   1'b0, 1'b0, 64'd0,     11'd0},
        '{64'd100,   1'b1, 1'b1, 64'd100,   11'd3},
        '{64'd0,     1'b0, 1'b0, 64'd0,     11'd0},
        '{64'd3,     1'b0, 1'b0, 64'd0,     11'd0},
        '{64'd7,     1'b0, 1'b0, 64'd0,     11'd0},
        '{64'd9,     1'b0, 1'b0, 64'd0,     11'd0},
        '{64'd10,    1'b1, 1'b1, 64'd0,     11'd1},
        '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'd0, 11'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'd0, 11'd0},
        '{64'h8000_0000_0000_0000, 1'b1, 1'b0, 64'd0, 11'd0}
    };

    initial
    begin
        bin_result_t e;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        sample_value = '0;
        is_final     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_USE_OVERRIDE;
        cfg_data     = '0;
        errors       = 0;
        quiet        = 1'b0;
        set_size     = 0;
        set_min      = ALL_ONES;
        set_max      = '0;
        range_cfg    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with typed bin 0 expectations where they are obvious.
        foreach (directed[k])
        begin
            send_item(directed[k].value, directed[k].fin);
            if (directed[k].chk)
            begin
                e = pending_bins[pending_bins.size() - BINS];
                if (e.lo !== directed[k].exp_lo || e.cnt !== directed[k].exp_cnt0)
                    report($sformatf("directed row %0d: bin 0 prediction off", k));
            end
        end

        // Large set with a crowded first bin, so the bars are scaled.
        quiet = 1'b1;
        for (int i = 0; i < BIG_SET; i++)
            send_item((i < 52) ? 64'd1000 : 64'd1000 + $urandom_range(0, 99),
                      i == BIG_SET - 1);
        random_sets(16);
        quiet = 1'b0;

        // Override with a narrow range, then a single-value set where it is rejected.
        set_range(1'b1, {$urandom, $urandom} & 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000);
        send_item(64'd42, 1'b1);
        random_sets(10);

        // Inverted override, so the range wraps.
        set_range(1'b1, ALL_ONES, 64'd0);
        random_sets(10);

        // Widest override.
        set_range(1'b1, 64'd0, ALL_ONES);
        random_sets(10);

        // Back to observed bounds.
        set_range(1'b0, 64'd0, 64'd0);
        random_sets(10);

        wait_drain();
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
